FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define CRT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define CRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types and constants of the CSV record tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] SEP_RESET = 8'd44;

    // Register map: one register, index taken from paddr[2]
    localparam int         ADDR_W        = 3;
    localparam logic [0:0] REG_SEPARATOR = 1'b0;

    // Depth of the queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_FEND    = 3'd1,
        KIND_LAST    = 3'd2,
        KIND_ERROR   = 3'd3,
        KIND_EXHAUST = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PH_LINE    = 3'd0,
        PH_FSTART  = 3'd1,
        PH_UNQ     = 3'd2,
        PH_QUOTED  = 3'd3,
        PH_QSEEN   = 3'd4,
        PH_AFTERQ  = 3'd5,
        PH_SEPHELD = 3'd6,
        PH_DROP    = 3'd7
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  field_byte;
        logic [7:0]  spaces;
        logic [15:0] lines;
    } result_t;

    // One queue entry: the results of one input word, one or two of them
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

    function automatic result_t mk_result(kind_t k, logic [7:0] b, logic [7:0] sp,
                                          logic [15:0] ln);
        result_t r;
        r.kind       = k;
        r.field_byte = b;
        r.spaces     = sp;
        r.lines      = ln;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/crt_queue.sv
// ----------------------------------------------------------------------------
// crt_queue
// Small register queue of result entries between parser front and emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crt_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  crt_pkg::entry_t      push_entry,
    output logic                 full,
    input  wire logic            pop,
    output logic                 empty,
    output crt_pkg::entry_t      head
);
    import crt_pkg::*;

    entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: src/crt_front.sv
// ----------------------------------------------------------------------------
// crt_front
// Parser front: takes one byte per cycle while the queue is not full, updates
// the parse state and builds the entry of up to two results for that byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crt_front #(
    parameter int MAX_PENDING_SPACES = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  text_byte,
    input  wire logic        end_of_input,
    input  wire logic [7:0]  separator_char,
    input  wire logic        q_full,
    output logic             push,
    output crt_pkg::entry_t  push_entry
);
    import crt_pkg::*;

    localparam int             PW       = $clog2(MAX_PENDING_SPACES + 1);
    localparam int             SPW      = (PW > 8) ? PW : 8;
    localparam logic [PW-1:0]  PEND_MAX = PW'(MAX_PENDING_SPACES);
    localparam logic [PW-1:0]  PEND_ONE = PW'(1);

    phase_t         phase_reg, phase_next;
    logic [PW-1:0]  pend_reg, pend_next;
    logic [15:0]    lines_reg, lines_next;

    logic           acc;
    logic           is_nl, is_blank, is_space, is_quote, is_sep;
    logic [SPW-1:0] pend_wide;
    logic [7:0]     sp8;
    logic [15:0]    lines_plus;

    // field-start and after-quote helpers
    phase_t         fs_phase;
    logic           fs_emit, fs_data;
    result_t        fs_res;
    phase_t         aq_phase;

    logic           e_v0, e_two;
    result_t        e_r0, e_r1;

    assign in_ready = !q_full;
    assign acc      = in_valid && in_ready;

    assign is_nl    = (text_byte == CH_NL);
    assign is_space = (text_byte == CH_SPACE);
    assign is_blank = is_space || (text_byte == CH_TAB);
    assign is_quote = (text_byte == CH_QUOTE);
    assign is_sep   = (text_byte == separator_char);

    assign pend_wide  = SPW'(pend_reg);
    assign sp8        = pend_wide[7:0];
    // a line is counted at its first byte; pending acts as the counted mark
    assign lines_plus = (pend_reg == '0 && lines_reg != 16'hFFFF) ?
                        lines_reg + 16'd1 : lines_reg;

    always_comb
    begin
        fs_phase = PH_UNQ;
        fs_emit  = 1'b1;
        fs_data  = 1'b0;
        fs_res   = mk_result(KIND_DATA, text_byte, 8'd0, 16'd0);
        if (is_blank)
        begin
            fs_phase = PH_FSTART;
            fs_emit  = 1'b0;
        end
        else if (is_nl)
        begin
            fs_phase = PH_LINE;
            fs_res   = mk_result(KIND_LAST, 8'd0, 8'd0, lines_reg);
        end
        else if (is_quote)
        begin
            fs_phase = PH_QUOTED;
            fs_emit  = 1'b0;
        end
        else if (is_sep)
        begin
            fs_phase = PH_FSTART;
            fs_res   = mk_result(KIND_FEND, 8'd0, 8'd0, 16'd0);
        end
        else
        begin
            fs_data = 1'b1;
        end

        if (is_nl)
        begin
            aq_phase = PH_LINE;
        end
        else if (is_blank)
        begin
            aq_phase = PH_AFTERQ;
        end
        else if (is_sep)
        begin
            aq_phase = PH_SEPHELD;
        end
        else
        begin
            aq_phase = PH_DROP;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        lines_next = lines_reg;
        if (acc)
        begin
            if (end_of_input)
            begin
                phase_next = PH_LINE;
                pend_next  = '0;
                lines_next = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LINE:
                    begin
                        lines_next = lines_plus;
                        if (is_nl)
                        begin
                            pend_next = '0;
                        end
                        else if (is_blank)
                        begin
                            pend_next = PEND_ONE;
                        end
                        else
                        begin
                            pend_next  = '0;
                            phase_next = fs_phase;
                        end
                    end
                    PH_FSTART, PH_SEPHELD:
                    begin
                        phase_next = fs_phase;
                        if (is_nl)
                        begin
                            pend_next  = '0;
                            lines_next = '0;
                        end
                        else if (fs_data)
                        begin
                            pend_next = '0;
                        end
                    end
                    PH_UNQ:
                    begin
                        if (is_nl)
                        begin
                            phase_next = PH_LINE;
                            pend_next  = '0;
                            lines_next = '0;
                        end
                        else if (is_sep)
                        begin
                            phase_next = PH_FSTART;
                            pend_next  = '0;
                        end
                        else if (is_space)
                        begin
                            if (pend_reg < PEND_MAX)
                            begin
                                pend_next = pend_reg + PEND_ONE;
                            end
                        end
                        else
                        begin
                            pend_next = '0;
                        end
                    end
                    PH_QUOTED:
                    begin
                        if (is_nl)
                        begin
                            phase_next = PH_LINE;
                            pend_next  = '0;
                            lines_next = '0;
                        end
                        else if (is_quote)
                        begin
                            phase_next = PH_QSEEN;
                        end
                    end
                    PH_QSEEN, PH_AFTERQ:
                    begin
                        if (phase_reg == PH_QSEEN && is_quote)
                        begin
                            phase_next = PH_QUOTED;
                        end
                        else
                        begin
                            phase_next = aq_phase;
                            if (is_nl)
                            begin
                                pend_next  = '0;
                                lines_next = '0;
                            end
                            else if (aq_phase == PH_DROP)
                            begin
                                lines_next = '0;
                            end
                        end
                    end
                    PH_DROP:
                    begin
                        if (is_nl)
                        begin
                            phase_next = PH_LINE;
                            pend_next  = '0;
                            lines_next = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_LINE;
                    end
                endcase
            end
        end
    end

    // results of this byte
    always_comb
    begin
        e_v0 = 1'b0;
        e_two = 1'b0;
        e_r0 = mk_result(KIND_DATA, 8'd0, 8'd0, 16'd0);
        e_r1 = mk_result(KIND_EXHAUST, 8'd0, 8'd0, 16'd0);
        if (end_of_input)
        begin
            e_v0 = 1'b1;
            unique case (phase_reg)
                PH_LINE:  e_r0 = mk_result(KIND_EXHAUST, 8'd0, 8'd0, lines_reg);
                PH_DROP:  e_r0 = mk_result(KIND_EXHAUST, 8'd0, 8'd0, 16'd0);
                PH_UNQ:
                begin
                    e_two = 1'b1;
                    e_r0  = mk_result(KIND_LAST, 8'd0, sp8, lines_reg);
                end
                default:
                begin
                    e_two = 1'b1;
                    e_r0  = mk_result(KIND_LAST, 8'd0, 8'd0, lines_reg);
                end
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_LINE:
                begin
                    if (!is_nl && !is_blank)
                    begin
                        e_v0 = fs_emit;
                        e_r0 = fs_res;
                    end
                end
                PH_FSTART:
                begin
                    e_v0 = fs_emit;
                    e_r0 = fs_res;
                end
                PH_UNQ:
                begin
                    if (is_nl)
                    begin
                        e_v0 = 1'b1;
                        e_r0 = mk_result(KIND_LAST, 8'd0, sp8, lines_reg);
                    end
                    else if (is_sep)
                    begin
                        e_v0 = 1'b1;
                        e_r0 = mk_result(KIND_FEND, 8'd0, 8'd0, 16'd0);
                    end
                    else if (!is_space)
                    begin
                        e_v0 = 1'b1;
                        e_r0 = mk_result(KIND_DATA, text_byte, sp8, 16'd0);
                    end
                end
                PH_QUOTED:
                begin
                    if (is_nl)
                    begin
                        e_v0 = 1'b1;
                        e_r0 = mk_result(KIND_LAST, 8'd0, 8'd0, lines_reg);
                    end
                    else if (!is_quote)
                    begin
                        e_v0 = 1'b1;
                        e_r0 = mk_result(KIND_DATA, text_byte, 8'd0, 16'd0);
                    end
                end
                PH_QSEEN, PH_AFTERQ:
                begin
                    if (phase_reg == PH_QSEEN && is_quote)
                    begin
                        e_v0 = 1'b1;
                        e_r0 = mk_result(KIND_DATA, text_byte, 8'd0, 16'd0);
                    end
                    else if (is_nl)
                    begin
                        e_v0 = 1'b1;
                        e_r0 = mk_result(KIND_LAST, 8'd0, 8'd0, lines_reg);
                    end
                    else if (aq_phase == PH_DROP)
                    begin
                        e_v0 = 1'b1;
                        e_r0 = mk_result(KIND_ERROR, 8'd0, 8'd0, lines_reg);
                    end
                end
                PH_SEPHELD:
                begin
                    e_v0 = 1'b1;
                    if (is_nl)
                    begin
                        e_r0 = mk_result(KIND_LAST, 8'd0, 8'd0, lines_reg);
                    end
                    else
                    begin
                        // held field end, then whatever starts the next field
                        e_r0  = mk_result(KIND_FEND, 8'd0, 8'd0, 16'd0);
                        e_two = fs_emit;
                        e_r1  = fs_res;
                    end
                end
                PH_DROP:
                begin
                    e_v0 = 1'b0;
                end
                default:
                begin
                    e_v0 = 1'b0;
                end
            endcase
        end
    end

    assign push           = acc && e_v0;
    assign push_entry.two = e_two;
    assign push_entry.r0  = e_r0;
    assign push_entry.r1  = e_r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LINE;
            pend_reg  <= '0;
            lines_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            lines_reg <= lines_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/crt_back.sv
// ----------------------------------------------------------------------------
// crt_back
// Emitter: unpacks queue entries into single result words and holds them
// in the output register until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crt_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_empty,
    input  crt_pkg::entry_t  head,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output crt_pkg::result_t out_result,
    output logic             out_last
);
    import crt_pkg::*;

    logic    valid_reg, valid_next;
    logic    half_reg, half_next;
    result_t res_reg;
    logic    last_reg;

    logic    take;
    logic    cur_last;
    result_t cur;

    assign cur      = half_reg ? head.r1 : head.r0;
    assign cur_last = half_reg || !head.two;
    assign take     = (!valid_reg || out_ready) && !q_empty;
    assign pop      = take && cur_last;

    always_comb
    begin
        valid_next = valid_reg;
        half_next  = half_reg;
        if (take)
        begin
            valid_next = 1'b1;
            half_next  = !cur_last;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg  <= cur;
            last_reg <= cur_last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = res_reg;
    assign out_last   = last_reg;

endmodule

`default_nettype wire

FILE: src/csv_record_tokenizer.sv
// Path: a byte's results are written into the queue, then into the output register.
// Throughput: one byte per cycle in while the queue has room; one result word per
//   cycle out while the receiver is ready. A byte with two results leaves as two
//   words, absorbed by the 4-entry queue. Input side stalls only when that queue is full.
// Reset (rst_n low, async): line-start state, counters cleared, queue and
//   output register empty, separator back to comma.
// ----------------------------------------------------------------------------
// csv_record_tokenizer
// Streaming CSV tokenizer with quoted fields, blank-line skipping and
// trailing-space counting; APB register for the separator byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csv_record_tokenizer #(
    parameter int MAX_PENDING_SPACES = 255
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // input stream
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [7:0]                 s_axis_tdata,   // [7:0] text_byte
    input  wire logic                       s_axis_tuser,   // [0] end_of_input
    // result stream
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [31:0]                     m_axis_tdata,   // [7:0] field_byte,
                                                            // [15:8] spaces_before,
                                                            // [31:16] lines_used
    output logic [2:0]                      m_axis_tuser,   // [2:0] kind
    output logic                            m_axis_tlast,   // last_of_run
    // register port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [crt_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import crt_pkg::*;

    logic [7:0] sep_reg, sep_next;
    logic       cfg_wr;

    logic       q_full, q_empty, q_push, q_pop;
    entry_t     q_in, q_head;
    result_t    res;

    // ---- register port: single separator register, zero wait states ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        sep_next = sep_reg;
        if (cfg_wr && paddr[2] == REG_SEPARATOR)
        begin
            sep_next = pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_SEPARATOR)
        begin
            prdata = {24'd0, sep_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg <= SEP_RESET;
        end
        else
        begin
            sep_reg <= sep_next;
        end
    end

    // ---- front: parse state machine, one byte per cycle while the queue has room ----
    crt_front #(
        .MAX_PENDING_SPACES(MAX_PENDING_SPACES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .text_byte     (s_axis_tdata),
        .end_of_input  (s_axis_tuser),
        .separator_char(sep_reg),
        .q_full        (q_full),
        .push          (q_push),
        .push_entry    (q_in)
    );

    // ---- queue decouples the parser from output backpressure ----
    crt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_entry(q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // ---- back: one result word per cycle into the output register when it is free or taken ----
    crt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_result(res),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {res.lines, res.spaces, res.field_byte};
    assign m_axis_tuser = res.kind;

endmodule

`default_nettype wire

FILE: src/crt_checker.sv
// ----------------------------------------------------------------------------
// crt_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module crt_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata,
    input  wire logic [2:0]  m_axis_tuser,
    input  wire logic        m_axis_tlast
);
    import crt_pkg::*;

    // only data words carry a byte
    `CRT_ASSERT_IMPL(a_byte_only_on_data, clk, rst_n,
        m_axis_tvalid && m_axis_tuser != KIND_DATA, m_axis_tdata[7:0] == 8'd0,
        "field byte set on a non-data word")

    // data words and field ends carry no line count
    `CRT_ASSERT_IMPL(a_no_lines_on_field, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == KIND_DATA || m_axis_tuser == KIND_FEND),
        m_axis_tdata[31:16] == 16'd0, "line count on a data word or field end")

    // end of input is always the final word of its input
    `CRT_ASSERT_IMPL(a_exhaust_is_last, clk, rst_n,
        m_axis_tvalid && m_axis_tuser == KIND_EXHAUST, m_axis_tlast,
        "input exhausted word not marked last")

    // a stalled word is held
    `CRT_ASSERT_NEXT(a_stall_hold, clk, rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result word changed while stalled")

endmodule

bind csv_record_tokenizer crt_checker u_crt_checker (.*);

`default_nettype wire

FILE: bench/csv_tokenizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_tokenizer_checker
// Watches both streams and the register port of the CSV tokenizer, predicts
// the result words of every accepted byte and compares them in order.
// ----------------------------------------------------------------------------

module csv_tokenizer_checker #(
    parameter int MAX_PENDING_SPACES = 255
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] text_byte
    input  logic                       s_axis_tuser,   // [0] end_of_input
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [31:0]                m_axis_tdata,   // [7:0] field_byte,
                                                       // [15:8] spaces_before,
                                                       // [31:16] lines_used
    input  logic [2:0]                 m_axis_tuser,   // [2:0] kind
    input  logic                       m_axis_tlast,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [crt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pready,
    output int                         mismatches,
    output int                         outstanding,
    output int                         words_in,
    output int                         results_checked,
    output int                         records_done,
    output int                         format_errors
);
    import crt_pkg::*;

    typedef struct {
        kind_t       kind;
        logic [7:0]  field_byte;
        logic [7:0]  spaces;
        logic [15:0] lines;
        logic        last;
    } tok_word_t;

    tok_word_t expected_words[$];
    tok_word_t step_words[$];
    tok_word_t want;

    // predictor state
    logic [7:0] sep_value;
    phase_t     phase;
    int         trail_spaces;
    int         lines_seen;

    function automatic void emit(kind_t k, logic [7:0] b, int sp, int ln);
        tok_word_t t;
        t.kind       = k;
        t.field_byte = b;
        t.spaces     = sp[7:0];
        t.lines      = ln[15:0];
        t.last       = 1'b0;
        step_words.push_back(t);
    endfunction

    function automatic void close_record(int sp);
        emit(KIND_LAST, 8'h00, sp, lines_seen);
        lines_seen   = 0;
        trail_spaces = 0;
        phase        = PH_LINE;
    endfunction

    function automatic void begin_field(logic [7:0] c);
        if (c == CH_SPACE || c == CH_TAB)
            phase = PH_FSTART;
        else if (c == CH_NL)
            close_record(0);
        else if (c == CH_QUOTE)
            phase = PH_QUOTED;
        else if (c == sep_value)
        begin
            emit(KIND_FEND, 8'h00, 0, 0);
            phase = PH_FSTART;
        end
        else
        begin
            emit(KIND_DATA, c, 0, 0);
            trail_spaces = 0;
            phase        = PH_UNQ;
        end
    endfunction

    // Whatever follows a closing quote: blanks, separator, line end or junk.
    function automatic void past_quote(logic [7:0] c);
        if (c == CH_NL)
            close_record(0);
        else if (c == CH_SPACE || c == CH_TAB)
            phase = PH_AFTERQ;
        else if (c == sep_value)
            phase = PH_SEPHELD;
        else
        begin
            emit(KIND_ERROR, 8'h00, 0, lines_seen);
            lines_seen = 0;
            phase      = PH_DROP;
        end
    endfunction

    function automatic void tokenize_byte(logic [7:0] c, logic eoi);
        step_words.delete();
        if (eoi)
        begin
            case (phase)
                PH_LINE: ;
                PH_DROP: lines_seen = 0;
                PH_UNQ:  close_record(trail_spaces);
                default: close_record(0);
            endcase
            emit(KIND_EXHAUST, 8'h00, 0, lines_seen);
            lines_seen   = 0;
            trail_spaces = 0;
            phase        = PH_LINE;
        end
        else
        begin
            case (phase)
                PH_LINE:
                begin
                    // line start: trail_spaces flags a whitespace line already counted
                    if (trail_spaces == 0 && lines_seen < 65535)
                        lines_seen++;
                    if (c == CH_NL)
                        trail_spaces = 0;
                    else if (c == CH_SPACE || c == CH_TAB)
                        trail_spaces = 1;
                    else
                    begin
                        trail_spaces = 0;
                        begin_field(c);
                    end
                end
                PH_FSTART:
                    begin_field(c);
                PH_UNQ:
                begin
                    if (c == CH_NL)
                        close_record(trail_spaces);
                    else if (c == sep_value)
                    begin
                        emit(KIND_FEND, 8'h00, 0, 0);
                        trail_spaces = 0;
                        phase        = PH_FSTART;
                    end
                    else if (c == CH_SPACE)
                    begin
                        if (trail_spaces < MAX_PENDING_SPACES)
                            trail_spaces++;
                    end
                    else
                    begin
                        emit(KIND_DATA, c, trail_spaces, 0);
                        trail_spaces = 0;
                    end
                end
                PH_QUOTED:
                begin
                    if (c == CH_NL)
                        close_record(0);
                    else if (c == CH_QUOTE)
                        phase = PH_QSEEN;
                    else
                        emit(KIND_DATA, c, 0, 0);
                end
                PH_QSEEN:
                begin
                    if (c == CH_QUOTE)
                    begin
                        emit(KIND_DATA, c, 0, 0);
                        phase = PH_QUOTED;
                    end
                    else
                        past_quote(c);
                end
                PH_AFTERQ:
                    past_quote(c);
                PH_SEPHELD:
                begin
                    // held field end turns into the record end on a line end
                    if (c == CH_NL)
                        close_record(0);
                    else
                    begin
                        emit(KIND_FEND, 8'h00, 0, 0);
                        begin_field(c);
                    end
                end
                default:
                begin
                    if (c == CH_NL)
                    begin
                        lines_seen   = 0;
                        trail_spaces = 0;
                        phase        = PH_LINE;
                    end
                end
            endcase
        end
        if (step_words.size() != 0)
            step_words[step_words.size() - 1].last = 1'b1;
        foreach (step_words[i])
            expected_words.push_back(step_words[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_value       = SEP_RESET;
            phase           = PH_LINE;
            trail_spaces    = 0;
            lines_seen      = 0;
            expected_words.delete();
            outstanding     = 0;
            mismatches      = 0;
            words_in        = 0;
            results_checked = 0;
            records_done    = 0;
            format_errors   = 0;
        end
        else
        begin
            // outputs first: a word accepted now belongs to an earlier byte
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected: kind %0d byte %h sp %0d lines %0d last %b",
                                 $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8],
                                 m_axis_tdata[31:16], m_axis_tlast);
                end
                else
                begin
                    want = expected_words.pop_front();
                    results_checked++;
                    if (want.kind == KIND_LAST)
                        records_done++;
                    if (want.kind == KIND_ERROR)
                        format_errors++;
                    if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.field_byte ||
                        m_axis_tdata[15:8] !== want.spaces ||
                        m_axis_tdata[31:16] !== want.lines || m_axis_tlast !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: want kind %0d byte %h sp %0d lines %0d last %b, got kind %0d byte %h sp %0d lines %0d last %b",
                                     $time, want.kind, want.field_byte, want.spaces,
                                     want.lines, want.last, m_axis_tuser, m_axis_tdata[7:0],
                                     m_axis_tdata[15:8], m_axis_tdata[31:16], m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                tokenize_byte(s_axis_tdata, s_axis_tuser);
                words_in++;
            end
            if (psel && penable && pwrite && pready &&
                paddr[crt_pkg::ADDR_W-1] == REG_SEPARATOR)
                sep_value = pwdata[7:0];
            outstanding = expected_words.size();
        end
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the CSV tokenizer bench: drives the byte stream and the separator
// register, throttles the result stream, and reports the checker's verdict.
// ----------------------------------------------------------------------------

module tb;
    import crt_pkg::*;

    localparam int SPACE_LIMIT  = 255;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int DRAIN_CYCLES = 8;        // covers the output queue and register
    localparam int PHASE_WORDS  = 105;      // random words per separator setting
    localparam int BLANK_RUN    = 12;       // blank lines counted into one record

    localparam logic [7:0] STRAY_BYTE = 8'h6A;  // junk after a closing quote

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;   // [7:0] text_byte
    logic                s_axis_tuser;   // [0] end_of_input
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [31:0]         m_axis_tdata;   // [7:0] field_byte, [15:8] spaces_before,
                                         // [31:16] lines_used
    logic [2:0]          m_axis_tuser;   // [2:0] kind
    logic                m_axis_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int mismatches;
    int outstanding;
    int words_in;
    int results_checked;
    int records_done;
    int format_errors;

    // pending stimulus, one entry per word: {end_of_input, text_byte}
    logic [8:0] stim_q[$];
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    logic [7:0] sep_now        = SEP_RESET;
    int         cycle_count    = 0;

    csv_record_tokenizer #(
        .MAX_PENDING_SPACES (SPACE_LIMIT)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    csv_tokenizer_checker #(
        .MAX_PENDING_SPACES (SPACE_LIMIT)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .words_in        (words_in),
        .results_checked (results_checked),
        .records_done    (records_done),
        .format_errors   (format_errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, outstanding);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side back-pressure, redrawn every cycle.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    function automatic void push_word(logic eoi, logic [7:0] b);
        stim_q.push_back({eoi, b});
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_word(1'b0, s[i]);
    endfunction

    function automatic logic [7:0] blank_byte();
        return $urandom_range(1) ? CH_SPACE : CH_TAB;
    endfunction

    // Field content: never a line end or the separator; no quote inside quotes.
    function automatic logic [7:0] content_byte(bit quoted);
        logic [7:0] b;
        do
        begin
            if ($urandom_range(1))
                b = 8'h61 + 8'($urandom_range(25));
            else
                b = 8'($urandom_range(255));
        end
        while (b == CH_NL || b == sep_now || (quoted && b == CH_QUOTE));
        return b;
    endfunction

    // First byte of an unquoted field must not look like a blank or a quote.
    function automatic logic [7:0] lead_byte();
        logic [7:0] b;
        do
            b = content_byte(1'b0);
        while (b == CH_SPACE || b == CH_TAB || b == CH_QUOTE);
        return b;
    endfunction

    // Noise leans on the bytes the parser reacts to.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(9))
            0:       return CH_SPACE;
            1:       return CH_NL;
            2:       return CH_QUOTE;
            3:       return sep_now;
            4:       return CH_TAB;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One record: mostly well formed with random content, some broken or noise.
    function automatic void gen_record();
        int pick;
        int nf;
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            repeat ($urandom_range(1, 12))
                push_word(1'b0, noise_byte());
            if ($urandom_range(3) == 0)
                push_word(1'b1, 8'($urandom_range(255)));
            return;
        end
        // blank and whitespace-only lines ahead of the record
        if ($urandom_range(4) == 0)
        begin
            repeat ($urandom_range(1, 2))
            begin
                repeat ($urandom_range(0, 3))
                    push_word(1'b0, blank_byte());
                push_word(1'b0, CH_NL);
            end
        end
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++)
        begin
            if (f > 0)
                push_word(1'b0, sep_now);
            if ($urandom_range(2) == 0)
                repeat ($urandom_range(1, 2))
                    push_word(1'b0, blank_byte());
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                push_word(1'b0, lead_byte());
                repeat ($urandom_range(0, 5))
                    push_word(1'b0, content_byte(1'b0));
                if ($urandom_range(2) == 0)
                    repeat ($urandom_range(1, 3))
                        push_word(1'b0, CH_SPACE);
            end
            else if (pick < 85)
            begin
                push_word(1'b0, CH_QUOTE);
                repeat ($urandom_range(0, 5))
                begin
                    if ($urandom_range(6) == 0)
                    begin
                        push_word(1'b0, CH_QUOTE);
                        push_word(1'b0, CH_QUOTE);
                    end
                    else
                        push_word(1'b0, content_byte(1'b1));
                end
                push_word(1'b0, CH_QUOTE);
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(1, 2))
                        push_word(1'b0, blank_byte());
                if ($urandom_range(9) == 0)
                    push_word(1'b0, STRAY_BYTE);
            end
            // else: empty field
        end
        pick = $urandom_range(99);
        if (pick < 85)
            push_word(1'b0, CH_NL);
        else if (pick < 95)
            push_word(1'b1, 8'($urandom_range(255)));
        else
        begin
            push_word(1'b0, CH_NL);
            push_word(1'b1, 8'($urandom_range(255)));
        end
    endfunction

    // ------------------------------------------------------------------
    // bus drivers; all called and returning at a falling edge
    // ------------------------------------------------------------------
    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 52; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            IDLE_BOTH:     begin send_idle_pct = 16; recv_stall_pct = 16; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic send_all();
        logic [8:0] w;
        while (stim_q.size() != 0)
        begin
            w = stim_q.pop_front();
            while ($urandom_range(99) < send_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= w[7:0];
            s_axis_tuser  <= w[8];
            do
            begin
                @(posedge clk);
            end
            while (!s_axis_tready);
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Wait for every expected word, then let bytes with no result settle.
    task automatic wait_drained();
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_separator(logic [7:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SEPARATOR, 2'b00};
        pwdata  <= {24'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sep_now = value;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] sep_pick;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = 32'h0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words, reset separator (comma):
        // whitespace-only line is skipped but counted
        push_text("\t\n");
        // 0xFF byte, trailing spaces dropped at the separator, doubled quote,
        // separator after a closing quote followed by a line end
        push_word(1'b0, 8'hFF);
        push_text("  ,\"\"\"\",\n");
        // junk after a closing quote: error, rest of line dropped
        push_text("\"x\"y\n");
        // unterminated quote closed by the line end
        push_text("\"z\n");
        // trailing space reported at the line end
        push_text("a \n");
        // end of input inside a quoted field with a 0x00 byte
        push_word(1'b0, CH_QUOTE);
        push_word(1'b0, 8'h00);
        push_word(1'b1, 8'h00);
        // end of input at line start
        push_word(1'b1, 8'hFF);
        send_all();

        // Random records, one separator setting per phase; the idle mix
        // rotates through all four handshake patterns across the phases.
        for (int p = 1; p <= 8; p++)
        begin
            case (p)
                1:       sep_pick = 8'h3B;
                2:       sep_pick = 8'h00;
                3:       sep_pick = 8'hFF;
                4:       sep_pick = CH_SPACE;
                5:       sep_pick = CH_TAB;
                6:       sep_pick = CH_QUOTE;
                7:       sep_pick = CH_NL;
                default: sep_pick = SEP_RESET;
            endcase
            write_separator(sep_pick);
            set_idle(idle_mode_t'(p % 4));
            if (p == 1)
            begin
                // space counter runs into its ceiling mid-field
                push_word(1'b0, 8'h6B);
                repeat (258) push_word(1'b0, CH_SPACE);
                push_text("m  \n");
            end
            while (stim_q.size() < PHASE_WORDS)
                gen_record();
            send_all();
        end

        // Line counting: a run of blank lines folded into one record.
        set_idle(IDLE_NONE);
        push_word(1'b1, 8'h00);
        repeat (BLANK_RUN) push_word(1'b0, CH_NL);
        push_text("x\n");
        push_word(1'b1, 8'h00);
        send_all();

        wait_drained();
        $display("Covered %0d input words over nine separator settings and four idle mixes.",
                 words_in);
        $display("Checked %0d result words: %0d records, %0d format errors.",
                 results_checked, records_done, format_errors);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
